FILE: src/sti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg
// Shared widths, register indexes, job codes and the quaternion term tables
// of the strapdown state integrator.
// ----------------------------------------------------------------------------
package sti_pkg;

   // Field widths.
   localparam int VAL_W      = 48;
   localparam int ATT_W      = 32;
   localparam int IN_W       = 32;
   localparam int DT_W       = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // Datapath widths.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 74;
   localparam int RND_W  = 42;
   localparam int QD_W   = 42;
   localparam int SPLIT  = 24;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CFG_POS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_POS_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_POS_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_ATT_W = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_ATT_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_ATT_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_ATT_Z = 3'd6;

   // Unity in Q2.30.
   localparam logic signed [ATT_W-1:0] Q_ONE = 32'sh4000_0000;

   // Rounding shift selects.
   localparam logic [1:0] RS_16 = 2'd0;
   localparam logic [1:0] RS_24 = 2'd1;
   localparam logic [1:0] RS_25 = 2'd2;
   localparam logic [1:0] RS_32 = 2'd3;

   // Job numbering of one integration step.
   localparam logic [4:0] J_VEL0  = 5'd0;
   localparam logic [4:0] J_POS0  = 5'd3;
   localparam logic [4:0] J_TERM0 = 5'd6;
   localparam logic [4:0] J_INC0  = 5'd18;
   localparam logic [4:0] J_SQ0   = 5'd22;
   localparam logic [4:0] J_LAST  = 5'd25;

   // Rate matrix terms: rate index, quaternion index, destination, negate.
   localparam int NUM_TERMS = 12;
   localparam logic [1:0] TERM_W [NUM_TERMS] =
      '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, 2'd0};
   localparam logic [1:0] TERM_Q [NUM_TERMS] =
      '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};
   localparam logic [1:0] TERM_D [NUM_TERMS] =
      '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
   localparam logic TERM_NEG [NUM_TERMS] =
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

   // Control of the multiply-accumulate unit.
   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic clr;
      logic sh24;
   } mac_ctl_type;

   // Control of the root and divide unit.
   typedef struct packed {
      logic start;
      logic root;
   } rd_ctl_type;

endpackage

FILE: src/sti_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_if
// Channel interfaces of the strapdown state integrator: request, response
// and register write.
// ----------------------------------------------------------------------------
interface sti_req_if import sti_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    restart;
   logic signed [IN_W-1:0]  accel_x;
   logic signed [IN_W-1:0]  accel_y;
   logic signed [IN_W-1:0]  accel_z;
   logic signed [IN_W-1:0]  rate_x;
   logic signed [IN_W-1:0]  rate_y;
   logic signed [IN_W-1:0]  rate_z;
   logic [DT_W-1:0]         step_time;

   modport source (output valid, restart, accel_x, accel_y, accel_z,
                   rate_x, rate_y, rate_z, step_time, input ready);
   modport sink (input valid, restart, accel_x, accel_y, accel_z,
                 rate_x, rate_y, rate_z, step_time, output ready);
endinterface

interface sti_rsp_if import sti_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] pos_x;
   logic signed [VAL_W-1:0] pos_y;
   logic signed [VAL_W-1:0] pos_z;
   logic signed [VAL_W-1:0] vel_x;
   logic signed [VAL_W-1:0] vel_y;
   logic signed [VAL_W-1:0] vel_z;
   logic signed [ATT_W-1:0] att_w;
   logic signed [ATT_W-1:0] att_x;
   logic signed [ATT_W-1:0] att_y;
   logic signed [ATT_W-1:0] att_z;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   att_w, att_x, att_y, att_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 att_w, att_x, att_y, att_z, output ready);
endinterface

interface sti_csr_if import sti_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/strapdown_state_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strapdown_state_integrator
// Fixed-point strapdown integrator of velocity, position and attitude.
// ----------------------------------------------------------------------------
// A restart beat reloads position and attitude from the start registers,
// zeroes velocity and shows that state on the response by way of the finish
// state and the response register. An integration beat runs 26 multiply jobs
// on one shared 33x33 multiplier, then a 32-step square root and four
// 32-step divisions for the normalization in a one-bit-per-cycle unit.
// The request side is not ready while a beat is at work; the finished state
// sits in a response register, so the next beat may start while it waits.
// Register writes are taken at any time and act at the next restart.
module strapdown_state_integrator import sti_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   sti_req_if.sink   req_bus,
   sti_rsp_if.source rsp_bus,
   sti_csr_if.sink   csr_bus
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_ACC   = 4'd2;
   localparam logic [3:0] S_RND   = 4'd3;
   localparam logic [3:0] S_USE   = 4'd4;
   localparam logic [3:0] S_RGO   = 4'd5;
   localparam logic [3:0] S_RWAIT = 4'd6;
   localparam logic [3:0] S_DGO   = 4'd7;
   localparam logic [3:0] S_DWAIT = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   localparam logic signed [42:0] QMAX = 43'sd2147483647;

   logic [3:0] state_ff, state_in;
   logic [4:0] job_ff;
   logic       part_ff;
   logic [1:0] k_ff;

   logic signed [VAL_W-1:0] cfg_pos_ff [3];
   logic signed [ATT_W-1:0] cfg_att_ff [4];
   logic signed [IN_W-1:0]  accel_ff [3];
   logic signed [IN_W-1:0]  rate_ff [3];
   logic [DT_W-1:0]         dt_ff;
   logic signed [VAL_W-1:0] vel_ff [3];
   logic signed [VAL_W-1:0] pos_ff [3];
   logic signed [ATT_W-1:0] att_ff [4];
   logic signed [QD_W-1:0]  qd_ff [4];
   logic signed [RND_W-1:0] rnd_ff;
   logic [31:0]             norm_ff;
   logic                    rsp_valid_ff;

   logic signed [VAL_W-1:0] out_pos_ff [3];
   logic signed [VAL_W-1:0] out_vel_ff [3];
   logic signed [ATT_W-1:0] out_att_ff [4];

   logic req_acc;
   logic rsp_free;

   // Job decode.
   logic       is_vel, is_pos, is_term, is_inc, is_sq;
   logic [4:0] rel;
   logic [1:0] ax;
   logic [3:0] tn;
   logic       last_part;
   logic [1:0] rsel;
   logic signed [MUL_W-1:0] mac_a, mac_b;
   mac_ctl_type mac_ctl;
   logic signed [ACC_W-1:0] acc;

   // Rounding.
   logic signed [ACC_W-1:0] bias;
   logic signed [ACC_W-1:0] rnd_sum;
   logic signed [ACC_W-1:0] rnd_sh;

   // Root and divide.
   rd_ctl_type  rd_ctl;
   logic        rd_done;
   logic [31:0] rd_result;
   logic [31:0] q_mag;
   logic [61:0] numer;

   function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W:0] s);
      if (s[VAL_W] != s[VAL_W-1]) begin
         sat48 = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
         sat48 = s[VAL_W-1:0];
      end
   endfunction

   function automatic logic signed [ATT_W-1:0] satq(input logic signed [42:0] s);
      logic signed [42:0] r;
      r = s;
      if (s > QMAX) begin
         r = QMAX;
      end else if (s < -QMAX) begin
         r = -QMAX;
      end
      satq = r[ATT_W-1:0];
   endfunction

   assign req_acc  = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   // Which job, which axis, which operands.
   always_comb begin
      is_vel  = (job_ff < J_POS0);
      is_pos  = (job_ff >= J_POS0)  && (job_ff < J_TERM0);
      is_term = (job_ff >= J_TERM0) && (job_ff < J_INC0);
      is_inc  = (job_ff >= J_INC0)  && (job_ff < J_SQ0);
      is_sq   = (job_ff >= J_SQ0);
      if (is_vel) begin
         rel = job_ff - J_VEL0;
      end else if (is_pos) begin
         rel = job_ff - J_POS0;
      end else if (is_term) begin
         rel = job_ff - J_TERM0;
      end else if (is_inc) begin
         rel = job_ff - J_INC0;
      end else begin
         rel = job_ff - J_SQ0;
      end
      ax = rel[1:0];
      tn = rel[3:0];
      last_part = (is_pos || is_inc) ? part_ff : 1'b1;
      mac_b = $signed({9'b0, dt_ff});
      rsel  = RS_16;
      if (is_vel) begin
         mac_a = {accel_ff[ax][IN_W-1], accel_ff[ax]};
      end else if (is_pos) begin
         rsel  = RS_32;
         mac_a = part_ff ? {{9{vel_ff[ax][VAL_W-1]}}, vel_ff[ax][VAL_W-1:SPLIT]}
                         : $signed({9'b0, vel_ff[ax][SPLIT-1:0]});
      end else if (is_term) begin
         rsel  = RS_24;
         mac_a = {rate_ff[TERM_W[tn]][IN_W-1], rate_ff[TERM_W[tn]]};
         mac_b = {att_ff[TERM_Q[tn]][ATT_W-1], att_ff[TERM_Q[tn]]};
      end else if (is_inc) begin
         rsel  = RS_25;
         mac_a = part_ff ? {{15{qd_ff[ax][QD_W-1]}}, qd_ff[ax][QD_W-1:SPLIT]}
                         : $signed({9'b0, qd_ff[ax][SPLIT-1:0]});
      end else begin
         mac_a = {att_ff[ax][ATT_W-1], att_ff[ax]};
         mac_b = {att_ff[ax][ATT_W-1], att_ff[ax]};
      end
      mac_ctl.mul_en = (state_ff == S_MUL);
      mac_ctl.acc_en = (state_ff == S_ACC);
      mac_ctl.clr    = !part_ff && !(is_sq && (job_ff != J_SQ0));
      mac_ctl.sh24   = part_ff;
   end

   sti_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   // Round to nearest, ties away from zero.
   always_comb begin
      case (rsel)
         RS_16:   bias = ACC_W'(64'd32768);
         RS_24:   bias = ACC_W'(64'd8388608);
         RS_25:   bias = ACC_W'(64'd16777216);
         default: bias = ACC_W'(64'd2147483648);
      endcase
      rnd_sum = acc + bias - $signed({{(ACC_W-1){1'b0}}, acc[ACC_W-1]});
      case (rsel)
         RS_16:   rnd_sh = rnd_sum >>> 16;
         RS_24:   rnd_sh = rnd_sum >>> 24;
         RS_25:   rnd_sh = rnd_sum >>> 25;
         default: rnd_sh = rnd_sum >>> 32;
      endcase
   end

   // Operands of the root and divide unit.
   always_comb begin
      q_mag  = att_ff[k_ff][ATT_W-1] ? 32'(-att_ff[k_ff]) : 32'(att_ff[k_ff]);
      numer  = {1'b0, q_mag[30:0], 30'b0} + {31'b0, norm_ff[31:1]};
      rd_ctl.start = (state_ff == S_RGO) || (state_ff == S_DGO);
      rd_ctl.root  = (state_ff == S_RGO);
   end

   sti_root_div u_root_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (rd_ctl),
      .radicand (acc[63:0]),
      .numer    (numer),
      .denom    (norm_ff),
      .done     (rd_done),
      .result   (rd_result)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_acc) state_in = req_bus.restart ? S_FIN : S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC: begin
            if (!last_part) begin
               state_in = S_MUL;
            end else if (is_sq) begin
               state_in = (job_ff == J_LAST) ? S_RGO : S_MUL;
            end else begin
               state_in = S_RND;
            end
         end
         S_RND:   state_in = S_USE;
         S_USE:   state_in = S_MUL;
         S_RGO:   state_in = S_RWAIT;
         S_RWAIT: if (rd_done) state_in = (rd_result == '0) ? S_FIN : S_DGO;
         S_DGO:   state_in = S_DWAIT;
         S_DWAIT: if (rd_done) state_in = (k_ff == 2'd3) ? S_FIN : S_DGO;
         S_FIN:   if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         job_ff       <= '0;
         part_ff      <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE) begin
            job_ff  <= J_VEL0;
            part_ff <= 1'b0;
         end else if (state_ff == S_ACC) begin
            if (!last_part) begin
               part_ff <= 1'b1;
            end else if (is_sq) begin
               job_ff  <= job_ff + 5'd1;
               part_ff <= 1'b0;
            end
         end else if (state_ff == S_USE) begin
            job_ff  <= job_ff + 5'd1;
            part_ff <= 1'b0;
         end
         if (state_ff == S_RWAIT) begin
            k_ff <= '0;
         end else if (state_ff == S_DWAIT && rd_done) begin
            k_ff <= k_ff + 2'd1;
         end
         if (state_ff == S_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Start registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) cfg_pos_ff[i] <= '0;
         cfg_att_ff[0] <= Q_ONE;
         for (int i = 1; i < 4; i++) cfg_att_ff[i] <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CFG_POS_X: cfg_pos_ff[0] <= csr_bus.data;
            CFG_POS_Y: cfg_pos_ff[1] <= csr_bus.data;
            CFG_POS_Z: cfg_pos_ff[2] <= csr_bus.data;
            CFG_ATT_W: cfg_att_ff[0] <= csr_bus.data[ATT_W-1:0];
            CFG_ATT_X: cfg_att_ff[1] <= csr_bus.data[ATT_W-1:0];
            CFG_ATT_Y: cfg_att_ff[2] <= csr_bus.data[ATT_W-1:0];
            CFG_ATT_Z: cfg_att_ff[3] <= csr_bus.data[ATT_W-1:0];
            default: ;
         endcase
      end
   end

   // Navigation state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vel_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
         att_ff[0] <= Q_ONE;
         for (int i = 1; i < 4; i++) att_ff[i] <= '0;
      end else begin
         if (req_acc && req_bus.restart) begin
            for (int i = 0; i < 3; i++) begin
               vel_ff[i] <= '0;
               pos_ff[i] <= cfg_pos_ff[i];
            end
            for (int i = 0; i < 4; i++) att_ff[i] <= cfg_att_ff[i];
         end
         if (state_ff == S_USE) begin
            if (is_vel) begin
               vel_ff[ax] <= sat48({vel_ff[ax][VAL_W-1], vel_ff[ax]}
                                   + {{7{rnd_ff[RND_W-1]}}, rnd_ff});
            end else if (is_pos) begin
               pos_ff[ax] <= sat48({pos_ff[ax][VAL_W-1], pos_ff[ax]}
                                   + {{7{rnd_ff[RND_W-1]}}, rnd_ff});
            end else if (is_inc) begin
               att_ff[ax] <= satq({{11{att_ff[ax][ATT_W-1]}}, att_ff[ax]}
                                  + {rnd_ff[RND_W-1], rnd_ff});
            end
         end
         // A zero quaternion falls back to the identity.
         if (state_ff == S_RWAIT && rd_done && rd_result == '0) begin
            att_ff[0] <= Q_ONE;
            for (int i = 1; i < 4; i++) att_ff[i] <= '0;
         end
         if (state_ff == S_DWAIT && rd_done) begin
            att_ff[k_ff] <= att_ff[k_ff][ATT_W-1] ? -$signed(rd_result)
                                                  : $signed(rd_result);
         end
      end
   end

   // Working registers of one step.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         accel_ff[0] <= req_bus.accel_x;
         accel_ff[1] <= req_bus.accel_y;
         accel_ff[2] <= req_bus.accel_z;
         rate_ff[0]  <= req_bus.rate_x;
         rate_ff[1]  <= req_bus.rate_y;
         rate_ff[2]  <= req_bus.rate_z;
         dt_ff       <= req_bus.step_time;
         for (int i = 0; i < 4; i++) qd_ff[i] <= '0;
      end else if (state_ff == S_USE && is_term) begin
         qd_ff[TERM_D[tn]] <= TERM_NEG[tn] ? qd_ff[TERM_D[tn]] - rnd_ff
                                           : qd_ff[TERM_D[tn]] + rnd_ff;
      end
      if (state_ff == S_RND) begin
         rnd_ff <= rnd_sh[RND_W-1:0];
      end
      if (state_ff == S_RWAIT && rd_done) begin
         norm_ff <= rd_result;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (state_ff == S_FIN && rsp_free) begin
         for (int i = 0; i < 3; i++) begin
            out_pos_ff[i] <= pos_ff[i];
            out_vel_ff[i] <= vel_ff[i];
         end
         for (int i = 0; i < 4; i++) out_att_ff[i] <= att_ff[i];
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.pos_x = out_pos_ff[0];
   assign rsp_bus.pos_y = out_pos_ff[1];
   assign rsp_bus.pos_z = out_pos_ff[2];
   assign rsp_bus.vel_x = out_vel_ff[0];
   assign rsp_bus.vel_y = out_vel_ff[1];
   assign rsp_bus.vel_z = out_vel_ff[2];
   assign rsp_bus.att_w = out_att_ff[0];
   assign rsp_bus.att_x = out_att_ff[1];
   assign rsp_bus.att_y = out_att_ff[2];
   assign rsp_bus.att_z = out_att_ff[3];

endmodule

FILE: src/sti_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_mac
// Shared signed 33x33 multiplier with a registered product and a wide
// accumulator that can add the product as is or shifted up by 24 bits.
// ----------------------------------------------------------------------------
module sti_mac import sti_pkg::*; (
   input  logic                     clock,
   input  mac_ctl_type              ctl,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   // Product register.
   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= op_a * op_b;
      end
   end

   // Accumulate, optionally restarting from zero.
   always_comb begin
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (ctl.sh24) begin
         prod_ext = prod_ext <<< SPLIT;
      end
      acc_in = (ctl.clr ? '0 : acc_ff) + prod_ext;
   end

   always_ff @(posedge clock) begin
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: src/sti_root_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_root_div
// One-bit-per-cycle unit that takes either the integer square root of a
// 64-bit value or the 32-bit quotient of a restoring division, through one
// shared subtractor.
// ----------------------------------------------------------------------------
module sti_root_div import sti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  rd_ctl_type         ctl,
   input  logic [63:0]        radicand,
   input  logic [61:0]        numer,
   input  logic [31:0]        denom,
   output logic               done,
   output logic [31:0]        result
);

   logic        busy_ff;
   logic        done_ff;
   logic        root_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] rn_ff;
   logic [63:0] rr_ff;
   logic [63:0] rbit_ff;
   logic [32:0] rem_ff;
   logic [31:0] quo_ff;
   logic [31:0] nlo_ff;
   logic [31:0] den_ff;

   logic [64:0] sub_x;
   logic [64:0] sub_y;
   logic [64:0] diff;
   logic        ge;
   logic [32:0] rem_sh;

   // Shared compare and subtract.
   always_comb begin
      rem_sh = {rem_ff[31:0], nlo_ff[31]};
      if (root_ff) begin
         sub_x = {1'b0, rn_ff};
         sub_y = {1'b0, rr_ff} + {1'b0, rbit_ff};
      end else begin
         sub_x = {32'b0, rem_sh};
         sub_y = {33'b0, den_ff};
      end
      diff = sub_x - sub_y;
      ge   = !diff[64];
   end

   // Control: a run of 32 steps per start.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 5'd31);
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath of both iterations.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         root_ff <= ctl.root;
         rn_ff   <= radicand;
         rr_ff   <= '0;
         rbit_ff <= 64'h4000_0000_0000_0000;
         rem_ff  <= {3'b0, numer[61:32]};
         nlo_ff  <= numer[31:0];
         den_ff  <= denom;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         if (root_ff) begin
            if (ge) begin
               rn_ff <= diff[63:0];
               rr_ff <= (rr_ff >> 1) + rbit_ff;
            end else begin
               rr_ff <= rr_ff >> 1;
            end
            rbit_ff <= rbit_ff >> 2;
         end else begin
            if (ge) begin
               rem_ff <= diff[32:0];
            end else begin
               rem_ff <= rem_sh;
            end
            quo_ff <= {quo_ff[30:0], ge};
            nlo_ff <= {nlo_ff[30:0], 1'b0};
         end
      end
   end

   assign done   = done_ff;
   assign result = root_ff ? rr_ff[31:0] : quo_ff;

endmodule

FILE: src/sti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_checker
// Port-level checks of the strapdown state integrator, bound to the top.
// ----------------------------------------------------------------------------
module sti_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_restart,
   input logic rsp_valid,
   input logic rsp_ready
);

   // No response beat right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The block is busy in the cycle after it takes a beat.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after an accepted beat");

   // A restart with an empty response side shows up after the finish state.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_restart && !rsp_valid) |-> ##2 rsp_valid)
      else $error("restart result missing");

   // A stalled response stays valid.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind strapdown_state_integrator sti_checker u_sti_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .req_restart (req_bus.restart),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready)
);
